// ===== rtl/dacn_pkg.sv =====
// ----------------------------------------------------------------------------
// dacn_pkg
// Shared types and constants for the dataset attribute to camel name converter.
// ----------------------------------------------------------------------------
package dacn_pkg;

  localparam int unsigned PREFIX_LEN = 5;
  localparam int unsigned POS_W      = 3;
  localparam int unsigned QDEPTH     = 2;
  localparam int unsigned QPTR_W     = $clog2(QDEPTH);
  localparam int unsigned QCNT_W     = QPTR_W + 1;

  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5a;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7a;
  localparam logic [7:0] CH_DASH    = 8'h2d;
  localparam logic [7:0] CH_D       = 8'h64;
  localparam logic [7:0] CH_T       = 8'h74;

  typedef struct packed {
    logic [7:0] result_byte;
    logic       byte_present;
    logic       name_done;
    logic       verdict;
  } result_t;

  // up to two result beats caused by one input beat
  typedef struct packed {
    result_t first;
    result_t second;
    logic    two;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // expected byte of "data-" at a prefix position
  function automatic logic [7:0] prefix_char(input logic [POS_W-1:0] pos);
    logic [7:0] c;
    unique case (pos)
      3'd0:    c = CH_D;
      3'd1:    c = CH_LOWER_A;
      3'd2:    c = CH_T;
      3'd3:    c = CH_LOWER_A;
      default: c = CH_DASH;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/dacn_ifs.sv =====
// ----------------------------------------------------------------------------
// dacn_ifs
// Valid/ready channel interfaces for name bytes in and result beats out.
// ----------------------------------------------------------------------------
interface dacn_name_if;
  logic       valid;
  logic       ready;
  logic [7:0] name_byte;
  logic       name_end;

  modport source (output valid, output name_byte, output name_end, input ready);
  modport sink   (input valid, input name_byte, input name_end, output ready);
endinterface

interface dacn_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] result_byte;
  logic       byte_present;
  logic       name_done;
  logic       verdict;

  modport source (output valid, output result_byte, output byte_present,
                  output name_done, output verdict, input ready);
  modport sink   (input valid, input result_byte, input byte_present,
                  input name_done, input verdict, output ready);
endinterface

// ===== rtl/dacn_front.sv =====
// ----------------------------------------------------------------------------
// dacn_front
// Prefix check and classification of each name byte into a result command.
// ----------------------------------------------------------------------------
module dacn_front
  import dacn_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] name_byte,
  input  logic       name_end,
  input  logic       q_ready,
  output logic       push,
  output cmd_t       cmd
);

  logic [POS_W-1:0] prefix_position, prefix_position_next;
  logic             dash_pending, dash_pending_next;
  logic             name_failed, name_failed_next;
  logic [1:0]       cnt;
  logic             accept;
  logic             is_up, is_low;

  assign in_ready = q_ready;
  assign accept   = in_valid && q_ready;
  assign is_up    = (name_byte >= CH_UPPER_A) && (name_byte <= CH_UPPER_Z);
  assign is_low   = (name_byte >= CH_LOWER_A) && (name_byte <= CH_LOWER_Z);

  always_comb begin
    prefix_position_next = prefix_position;
    dash_pending_next    = dash_pending;
    name_failed_next     = name_failed;
    cnt                  = 2'd0;
    cmd                  = '0;

    if (!name_failed) begin
      if (prefix_position < POS_W'(PREFIX_LEN)) begin
        if (name_byte != prefix_char(prefix_position)) begin
          name_failed_next = 1'b1;
        end else begin
          prefix_position_next = prefix_position + 1'b1;
        end
      end else if (is_up) begin
        name_failed_next = 1'b1;
      end else if (dash_pending) begin
        if (is_low) begin
          // case flip: lower and upper differ only in bit 5
          cmd.first = '{result_byte: name_byte & 8'hdf, byte_present: 1'b1,
                        name_done: 1'b0, verdict: 1'b0};
          cnt = 2'd1;
          dash_pending_next = 1'b0;
        end else begin
          cmd.first = '{result_byte: CH_DASH, byte_present: 1'b1,
                        name_done: 1'b0, verdict: 1'b0};
          cnt = 2'd1;
          if (name_byte != CH_DASH) begin
            cmd.second = '{result_byte: name_byte, byte_present: 1'b1,
                           name_done: 1'b0, verdict: 1'b0};
            cnt = 2'd2;
            dash_pending_next = 1'b0;
          end
        end
      end else if (name_byte == CH_DASH) begin
        dash_pending_next = 1'b1;
      end else begin
        cmd.first = '{result_byte: name_byte, byte_present: 1'b1,
                      name_done: 1'b0, verdict: 1'b0};
        cnt = 2'd1;
      end
    end

    if (name_end) begin
      priority if (name_failed_next || prefix_position_next < POS_W'(PREFIX_LEN)) begin
        cmd.first  = '{result_byte: 8'h00, byte_present: 1'b0,
                       name_done: 1'b1, verdict: 1'b1};
        cmd.second = '0;
        cnt        = 2'd1;
      end else if (dash_pending_next) begin
        // trailing dash goes out as the final beat
        if (cnt == 2'd0) begin
          cmd.first = '{result_byte: CH_DASH, byte_present: 1'b1,
                        name_done: 1'b1, verdict: 1'b0};
          cnt = 2'd1;
        end else begin
          cmd.second = '{result_byte: CH_DASH, byte_present: 1'b1,
                         name_done: 1'b1, verdict: 1'b0};
          cnt = 2'd2;
        end
      end else if (cnt == 2'd2) begin
        cmd.second.name_done = 1'b1;
      end else if (cnt == 2'd1) begin
        cmd.first.name_done = 1'b1;
      end else begin
        cmd.first = '{result_byte: 8'h00, byte_present: 1'b0,
                      name_done: 1'b1, verdict: 1'b0};
        cnt = 2'd1;
      end
      prefix_position_next = '0;
      dash_pending_next    = 1'b0;
      name_failed_next     = 1'b0;
    end

    cmd.two = (cnt == 2'd2);
  end

  assign push = accept && (cnt != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      prefix_position <= '0;
      dash_pending    <= 1'b0;
      name_failed     <= 1'b0;
    end else if (accept) begin
      prefix_position <= prefix_position_next;
      dash_pending    <= dash_pending_next;
      name_failed     <= name_failed_next;
    end
  end

endmodule

// ===== rtl/dacn_queue.sv =====
// ----------------------------------------------------------------------------
// dacn_queue
// Short command queue between the classifier and the result sequencer.
// ----------------------------------------------------------------------------
module dacn_queue
  import dacn_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  cmd_t    wr_cmd,
  input  logic    pop,
  output cmd_t    rd_cmd,
  output q_stat_t stat
);

  cmd_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push, do_pop;

  assign stat.full  = (count == QCNT_W'(QDEPTH));
  assign stat.empty = (count == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rd_cmd     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/dacn_back.sv =====
// ----------------------------------------------------------------------------
// dacn_back
// Result sequencer: unpacks commands into result beats through an output register.
// ----------------------------------------------------------------------------
module dacn_back
  import dacn_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    q_valid,
  input  cmd_t    q_cmd,
  output logic    pop,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  logic    hold_valid;
  result_t hold_data;
  logic    can_load;

  assign can_load = !out_valid || out_ready;
  assign pop      = can_load && !hold_valid && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      hold_valid <= 1'b0;
    end else if (can_load) begin
      if (hold_valid) begin
        out_valid  <= 1'b1;
        hold_valid <= 1'b0;
      end else if (q_valid) begin
        out_valid  <= 1'b1;
        hold_valid <= q_cmd.two;
      end else begin
        out_valid  <= 1'b0;
      end
    end
  end

  // payload: second beat of a command waits in the hold register
  always_ff @(posedge clk) begin
    if (can_load) begin
      if (hold_valid) begin
        out_data <= hold_data;
      end else if (q_valid) begin
        out_data  <= q_cmd.first;
        hold_data <= q_cmd.second;
      end
    end
  end

endmodule

// ===== rtl/dataset_attribute_to_camel_name_core.sv =====
// ----------------------------------------------------------------------------
// dataset_attribute_to_camel_name_core
// Converts "data-" attribute names, one byte a beat, to camel-case names.
// ----------------------------------------------------------------------------
// Takes one name byte per cycle while the queue has room and gives one
// result beat per cycle while the receiver is ready. Most bytes cause at
// most one result beat; a byte after a held dash that is neither a letter
// nor a dash flushes the dash and itself, and a final dash after a held dash
// gives the held dash and the trailing one. Such two-beat bytes leave the
// output register one beat at a time; a two-entry command queue absorbs
// that, so input keeps flowing at one byte per cycle until the queue fills.
// An accepted byte passes the queue and the output register before its
// first result beat. A name that fails gives a single final beat with
// verdict 1; beats sent earlier for it are to be dropped by the receiver.
module dataset_attribute_to_camel_name_core
  import dacn_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  dacn_name_if.sink    name_in,
  dacn_result_if.source result_out
);

  logic    q_push, q_pop;
  cmd_t    wr_cmd, rd_cmd;
  q_stat_t q_stat;
  result_t out_data;

  dacn_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (name_in.valid),
    .in_ready  (name_in.ready),
    .name_byte (name_in.name_byte),
    .name_end  (name_in.name_end),
    .q_ready   (!q_stat.full),
    .push      (q_push),
    .cmd       (wr_cmd)
  );

  dacn_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (q_push),
    .wr_cmd (wr_cmd),
    .pop    (q_pop),
    .rd_cmd (rd_cmd),
    .stat   (q_stat)
  );

  dacn_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (!q_stat.empty),
    .q_cmd     (rd_cmd),
    .pop       (q_pop),
    .out_valid (result_out.valid),
    .out_ready (result_out.ready),
    .out_data  (out_data)
  );

  assign result_out.result_byte  = out_data.result_byte;
  assign result_out.byte_present = out_data.byte_present;
  assign result_out.name_done    = out_data.name_done;
  assign result_out.verdict      = out_data.verdict;

`ifndef NO_ASSERTIONS
  // the classifier never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_stat.full)
    else $error("command pushed into full queue");

  // an empty beat only ever closes a name
  a_empty_beat: assert property (@(posedge clk) disable iff (rst)
    (result_out.valid && !result_out.byte_present) |->
      (result_out.name_done && result_out.result_byte == 8'h00))
    else $error("empty result beat that does not close a name");

  // a not-dataset verdict comes only on a closing empty beat
  a_verdict: assert property (@(posedge clk) disable iff (rst)
    (result_out.valid && result_out.verdict) |->
      (result_out.name_done && !result_out.byte_present))
    else $error("bad verdict on result beat");
`endif

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the dataset attribute to camel name converter.
// ----------------------------------------------------------------------------
// Feeds attribute names one byte a beat: a few hand-picked names first, then
// random names. Most are "data-" names with random bodies; the rest have a
// broken or cut prefix, or are plain noise. A scoreboard tracks prefix, held
// dash and failure per name, queues the result beats each accepted byte should
// cause, and checks every result beat against the oldest one. Both sides idle
// at random. The receiver also holds off for a long stretch at set beat
// counts, so the block fills up and stalls its input.
// ----------------------------------------------------------------------------

class camel_name_board;
  logic [2:0]         prefix_pos;
  bit                 dash_held;
  bit                 name_failed;
  logic [7:0]         prefix_text [0:4];
  dacn_pkg::result_t  expected_q [$];
  int unsigned        errors;

  function new();
    prefix_text = '{dacn_pkg::CH_D, dacn_pkg::CH_LOWER_A, dacn_pkg::CH_T,
                    dacn_pkg::CH_LOWER_A, dacn_pkg::CH_DASH};
    errors = 0;
    clear_name();
  endfunction

  function void clear_name();
    prefix_pos  = '0;
    dash_held   = 1'b0;
    name_failed = 1'b0;
  endfunction

  function dacn_pkg::result_t make_beat(logic [7:0] b, logic present, logic done,
                                        logic verdict);
    dacn_pkg::result_t r;
    r.result_byte  = b;
    r.byte_present = present;
    r.name_done    = done;
    r.verdict      = verdict;
    return r;
  endfunction

  // work out the result beats one accepted name byte causes
  function void note_name_beat(logic [7:0] b, logic last);
    dacn_pkg::result_t beats [$];
    bit                upper;
    bit                lower;
    upper = (b >= dacn_pkg::CH_UPPER_A) && (b <= dacn_pkg::CH_UPPER_Z);
    lower = (b >= dacn_pkg::CH_LOWER_A) && (b <= dacn_pkg::CH_LOWER_Z);
    if (!name_failed) begin
      if (prefix_pos < dacn_pkg::PREFIX_LEN) begin
        if (b != prefix_text[prefix_pos]) begin
          name_failed = 1'b1;
        end else begin
          prefix_pos = prefix_pos + 3'd1;
        end
      end else if (upper) begin
        name_failed = 1'b1;
      end else if (dash_held) begin
        if (lower) begin
          beats = {beats, make_beat(b - dacn_pkg::CH_LOWER_A + dacn_pkg::CH_UPPER_A,
                                    1'b1, 1'b0, 1'b0)};
          dash_held = 1'b0;
        end else begin
          beats = {beats, make_beat(dacn_pkg::CH_DASH, 1'b1, 1'b0, 1'b0)};
          // a second dash stays held
          if (b != dacn_pkg::CH_DASH) begin
            beats = {beats, make_beat(b, 1'b1, 1'b0, 1'b0)};
            dash_held = 1'b0;
          end
        end
      end else if (b == dacn_pkg::CH_DASH) begin
        dash_held = 1'b1;
      end else begin
        beats = {beats, make_beat(b, 1'b1, 1'b0, 1'b0)};
      end
    end
    if (last) begin
      if (name_failed || prefix_pos < dacn_pkg::PREFIX_LEN) begin
        beats.delete();
        beats = {beats, make_beat(8'h00, 1'b0, 1'b1, 1'b1)};
      end else if (dash_held) begin
        beats = {beats, make_beat(dacn_pkg::CH_DASH, 1'b1, 1'b1, 1'b0)};
      end else if (beats.size() > 0) begin
        beats[beats.size()-1].name_done = 1'b1;
      end else begin
        beats = {beats, make_beat(8'h00, 1'b0, 1'b1, 1'b0)};
      end
      clear_name();
    end
    expected_q = {expected_q, beats};
  endfunction

  function void check_result_beat(dacn_pkg::result_t got);
    dacn_pkg::result_t want;
    if (expected_q.size() == 0) begin
      $display("%0t: unexpected result beat: expected none, actual %h", $time, got);
      errors++;
      return;
    end
    want = expected_q.pop_front();
    if (got.result_byte !== want.result_byte) begin
      $display("%0t: result_byte mismatch: expected %02h, actual %02h",
               $time, want.result_byte, got.result_byte);
      errors++;
    end
    if (got.byte_present !== want.byte_present) begin
      $display("%0t: byte_present mismatch: expected %b, actual %b",
               $time, want.byte_present, got.byte_present);
      errors++;
    end
    if (got.name_done !== want.name_done) begin
      $display("%0t: name_done mismatch: expected %b, actual %b",
               $time, want.name_done, got.name_done);
      errors++;
    end
    if (got.verdict !== want.verdict) begin
      $display("%0t: verdict mismatch: expected %b, actual %b",
               $time, want.verdict, got.verdict);
      errors++;
    end
  endfunction

  function int unsigned pending();
    return expected_q.size();
  endfunction
endclass

module testbench;
  import dacn_pkg::*;

  typedef enum int {GAP_NONE, GAP_FULL, GAP_SPARSE} gap_mode_e;

  localparam int unsigned NAME_BYTES  = 1850;
  localparam int unsigned HOLD_CYCLES = 200;
  localparam int unsigned STALL_LIMIT = 3000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  dacn_name_if   name_in ();
  dacn_result_if result_out ();

  dataset_attribute_to_camel_name_core i_dut (
    .clk        (clk),
    .rst        (rst),
    .name_in    (name_in),
    .result_out (result_out)
  );

  camel_name_board board;
  logic [7:0]      name_q [$];
  gap_mode_e       tx_mode = GAP_NONE;
  gap_mode_e       rx_mode = GAP_NONE;
  int unsigned     bytes_in = 0;
  int unsigned     beats_out = 0;
  int unsigned     holds_done = 0;
  int unsigned     quiet_cycles = 0;
  bit              draining = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    name_in.valid     = 1'b0;
    name_in.name_byte = 8'h00;
    name_in.name_end  = 1'b0;
    result_out.ready  = 1'b0;
  end

  function int unsigned draw_gap(gap_mode_e mode);
    case (mode)
      GAP_NONE: return 0;
      GAP_FULL: return $urandom_range(0, 17);
      default:  return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 17) : 0;
    endcase
  endfunction

  function void load_text(string s);
    name_q.delete();
    for (int i = 0; i < s.len(); i++) name_q = {name_q, s[i]};
  endfunction

  function logic [7:0] body_byte();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40)      return 8'(CH_LOWER_A + $urandom_range(0, 25));
    else if (r < 65) return CH_DASH;
    else if (r < 75) return 8'(8'h30 + $urandom_range(0, 9));
    else if (r < 80) return 8'(CH_UPPER_A + $urandom_range(0, 25));
    else             return 8'($urandom_range(0, 255));
  endfunction

  function void build_random_name();
    int unsigned kind;
    int unsigned len;
    kind = $urandom_range(0, 99);
    if (kind < 8) begin
      name_q.delete();
      len = $urandom_range(1, 8);
      repeat (len) name_q = {name_q, 8'($urandom_range(0, 255))};
    end else begin
      load_text("data-");
      if (kind < 14) begin
        name_q[$urandom_range(0, 4)] = 8'($urandom_range(0, 255));
      end else if (kind < 18) begin
        // name ends inside the prefix
        len = $urandom_range(1, 4);
        name_q = name_q[0:len-1];
        return;
      end
      len = $urandom_range(0, 10);
      repeat (len) name_q = {name_q, body_byte()};
    end
  endfunction

  task automatic send_name_beat(logic [7:0] b, logic last);
    int unsigned gap;
    gap = draw_gap(tx_mode);
    if (gap > 0) begin
      name_in.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    name_in.valid     <= 1'b1;
    name_in.name_byte <= b;
    name_in.name_end  <= last;
    do @(posedge clk); while (!name_in.ready);
    board.note_name_beat(b, last);
    bytes_in++;
    @(negedge clk);
  endtask

  task automatic send_name();
    foreach (name_q[i]) send_name_beat(name_q[i], i == name_q.size() - 1);
  endtask

  // stimulus
  initial begin
    int unsigned names;
    board = new();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // ends inside the prefix
    load_text("d");
    send_name();
    // broken prefix, rest swallowed, extreme byte values
    name_q = '{8'hff, 8'h00};
    send_name();
    // nothing after the prefix
    load_text("data-");
    send_name();
    // dash-letter, dash-digit, dash-uppercase failure, swallowed tail
    load_text("data-q-z-7-Qa");
    send_name();
    // dash after dash and a trailing dash
    load_text("data---");
    send_name();

    names = 0;
    while (bytes_in < NAME_BYTES) begin
      if (names % 20 == 0) tx_mode = gap_mode_e'($urandom_range(0, 2));
      build_random_name();
      send_name();
      names++;
    end
    name_in.valid <= 1'b0;

    draining = 1'b1;
    while (board.pending() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  // result sink
  initial begin
    int unsigned       gap;
    dacn_pkg::result_t got;
    wait (!rst);
    @(negedge clk);
    forever begin
      // long hold-off so the block backs up into its input
      if (holds_done < 2 && beats_out >= 300 + holds_done * 600) begin
        result_out.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        holds_done++;
      end
      gap = draining ? 0 : draw_gap(rx_mode);
      if (gap > 0) begin
        result_out.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      result_out.ready <= 1'b1;
      do @(posedge clk); while (!result_out.valid);
      got.result_byte  = result_out.result_byte;
      got.byte_present = result_out.byte_present;
      got.name_done    = result_out.name_done;
      got.verdict      = result_out.verdict;
      board.check_result_beat(got);
      beats_out++;
      if (beats_out % 40 == 0) rx_mode = gap_mode_e'($urandom_range(0, 2));
      @(negedge clk);
    end
  end

  // watchdog on cycles with no beat moving on either side
  always @(posedge clk) begin
    if (rst || (name_in.valid && name_in.ready) ||
        (result_out.valid && result_out.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("testbench failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

// ===== sim.f =====
rtl/dacn_pkg.sv
rtl/dacn_ifs.sv
rtl/dacn_front.sv
rtl/dacn_queue.sv
rtl/dacn_back.sv
rtl/dataset_attribute_to_camel_name_core.sv
sim/testbench.sv
